FILE: design/ptpd_pkg.sv
// Package for the packed tile palette decoder: widths, command codes,
// register indexes, helper functions and the structs between modules.
// No dependencies.
`timescale 1ns / 1ps

package ptpd_pkg;

	// Field and storage widths.
	localparam int CMD_W       = 2;
	localparam int PAL_ADDR_W  = 4;
	localparam int PAL_WORD_W  = 16;
	localparam int PAL_ENTRY_W = 9;
	localparam int PAL_DEPTH   = 16;
	localparam int TILE_BYTES  = 32;
	localparam int TILE_ADDR_W = 5;
	localparam int BYTE_W      = 8;
	localparam int PIX_IDX_W   = 6;
	localparam int SIDE_W      = 9;
	localparam int CFG_W       = 10;
	localparam int COORD_W     = 12;
	localparam int COLOR_W     = 8;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [CFG_W-1:0] MAX_TILES_SIDE  = 10'd512;
	localparam logic [CFG_W-1:0] TILES_RESET_VAL = 10'd64;

	// Input commands.
	localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TILE    = 2'd2;

	// Configuration register indexes (paddr bit 2).
	localparam logic REG_TILES_WIDE = 1'b0;
	localparam logic REG_TILES_HIGH = 1'b1;

	// Request from the input control to start emitting a complete tile.
	typedef struct packed {
		logic              go;
		logic [SIDE_W-1:0] base_x;
		logic [SIDE_W-1:0] base_y;
	} ptpd_start_t;

	// Status of the pixel pipeline back to the input control.
	typedef struct packed {
		logic busy;
	} ptpd_status_t;

	// Limits a side register to the largest supported tile count.
	function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		clamp_side = (v > MAX_TILES_SIDE) ? MAX_TILES_SIDE : v;
	endfunction

	// Scales a 3-bit component by 36 as 32*c + 4*c.
	function automatic logic [COLOR_W-1:0] scale36(input logic [2:0] c);
		scale36 = {c, 5'b00000} + {3'b000, c, 2'b00};
	endfunction

endpackage

FILE: design/ptpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/ptpd_palette.sv
// Palette store: a 16-entry RAM plus per-entry valid bits so that entries
// never written read as zero after reset. Depends on ptpd_pkg and ptpd_ram.
`timescale 1ns / 1ps

module ptpd_palette (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [ptpd_pkg::PAL_ADDR_W-1:0]  waddr,
	input  logic [ptpd_pkg::PAL_ENTRY_W-1:0] wdata,
	input  logic                             re,
	input  logic [ptpd_pkg::PAL_ADDR_W-1:0]  raddr,
	output logic [ptpd_pkg::PAL_ENTRY_W-1:0] rdata
);

	logic [ptpd_pkg::PAL_DEPTH-1:0]   vld_q;
	logic                             rd_vld_q;
	logic [ptpd_pkg::PAL_ENTRY_W-1:0] ram_rdata;

	ptpd_ram #(
		.WIDTH(ptpd_pkg::PAL_ENTRY_W),
		.DEPTH(ptpd_pkg::PAL_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Valid bits are set on write and sampled alongside the RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? ram_rdata : '0;

endmodule

FILE: design/ptpd_cfg.sv
// APB-style configuration registers: tiles_wide at byte address 0 and
// tiles_high at byte address 4. Depends on ptpd_pkg.
`timescale 1ns / 1ps

module ptpd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ptpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ptpd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ptpd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [ptpd_pkg::CFG_W-1:0]      tiles_wide,
	output logic [ptpd_pkg::CFG_W-1:0]      tiles_high
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_wide <= ptpd_pkg::TILES_RESET_VAL;
			tiles_high <= ptpd_pkg::TILES_RESET_VAL;
		end else if (wr_en) begin
			unique case (paddr[2])
				ptpd_pkg::REG_TILES_WIDE: tiles_wide <= pwdata[ptpd_pkg::CFG_W-1:0];
				ptpd_pkg::REG_TILES_HIGH: tiles_high <= pwdata[ptpd_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (paddr[2])
			ptpd_pkg::REG_TILES_WIDE: prdata = {22'd0, tiles_wide};
			ptpd_pkg::REG_TILES_HIGH: prdata = {22'd0, tiles_high};
			default:                  prdata = '0;
		endcase
	end

endmodule

FILE: design/ptpd_emit.sv
// Pixel pipeline: walks the 64 pixels of a buffered tile, reads the tile
// buffer and then the palette, and holds each pixel in an output register.
// Depends on ptpd_pkg.
`timescale 1ns / 1ps

module ptpd_emit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ptpd_pkg::ptpd_start_t            start,
	output ptpd_pkg::ptpd_status_t           status,
	output logic                             tile_re,
	output logic [ptpd_pkg::TILE_ADDR_W-1:0] tile_raddr,
	input  logic [ptpd_pkg::BYTE_W-1:0]      tile_rdata,
	output logic                             pal_re,
	output logic [ptpd_pkg::PAL_ADDR_W-1:0]  pal_raddr,
	input  logic [ptpd_pkg::PAL_ENTRY_W-1:0] pal_rdata,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ptpd_pkg::COORD_W-1:0]     pixel_x,
	output logic [ptpd_pkg::COORD_W-1:0]     pixel_y,
	output logic [ptpd_pkg::COLOR_W-1:0]     red,
	output logic [ptpd_pkg::COLOR_W-1:0]     green,
	output logic [ptpd_pkg::COLOR_W-1:0]     blue,
	output logic                             transparent,
	output logic                             last
);

	localparam logic [ptpd_pkg::PIX_IDX_W-1:0] LAST_PIX = '1;

	logic                             act_q;
	logic [ptpd_pkg::PIX_IDX_W-1:0]   pix_q;
	logic [ptpd_pkg::SIDE_W-1:0]      base_x_q;
	logic [ptpd_pkg::SIDE_W-1:0]      base_y_q;
	logic                             valid_s1;
	logic [ptpd_pkg::PIX_IDX_W-1:0]   pix_s1;
	logic                             valid_s2;
	logic [ptpd_pkg::PIX_IDX_W-1:0]   pix_s2;
	logic                             zero_s2;
	logic                             out_valid_q;
	logic                             advance;
	logic [ptpd_pkg::PAL_ADDR_W-1:0]  nibble;

	// The whole pipeline moves whenever the output register can take a pixel.
	assign advance    = !out_valid_q || !out_stall;
	assign tile_re    = advance && act_q;
	assign tile_raddr = pix_q[ptpd_pkg::PIX_IDX_W-1:1];
	assign nibble     = pix_s1[0] ? tile_rdata[3:0] : tile_rdata[7:4];
	assign pal_re     = advance && valid_s1;
	assign pal_raddr  = nibble;
	assign status.busy = act_q || valid_s1 || valid_s2;
	assign out_valid  = out_valid_q;

	// Control: pixel sequencer and stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			pix_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start.go) begin
				act_q <= 1'b1;
				pix_q <= '0;
			end else if (tile_re) begin
				pix_q <= pix_q + 1'b1;
				if (pix_q == LAST_PIX) begin
					act_q <= 1'b0;
				end
			end
			if (advance) begin
				valid_s1    <= act_q;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
			end
		end
	end

	// Payload: tile origin, pixel index through the stages, output fields.
	always_ff @(posedge clk) begin
		if (start.go) begin
			base_x_q <= start.base_x;
			base_y_q <= start.base_y;
		end
		if (advance) begin
			pix_s1 <= pix_q;
			pix_s2 <= pix_s1;
			zero_s2 <= (nibble == '0);
			if (valid_s2) begin
				pixel_x     <= {base_x_q, pix_s2[2:0]};
				pixel_y     <= {base_y_q, pix_s2[5:3]};
				transparent <= zero_s2;
				last        <= (pix_s2 == LAST_PIX);
				red         <= zero_s2 ? '0 : ptpd_pkg::scale36(pal_rdata[2:0]);
				green       <= zero_s2 ? '0 : ptpd_pkg::scale36(pal_rdata[5:3]);
				blue        <= zero_s2 ? '0 : ptpd_pkg::scale36(pal_rdata[8:6]);
			end
		end
	end

endmodule

FILE: design/packed_tile_palette_decoder_top.sv
// Top level of the packed tile palette decoder: input command handling,
// tile position state, and the tile buffer, palette, register and pixel
// pipeline instances. Depends on ptpd_pkg and all ptpd_* modules.
`timescale 1ns / 1ps

// Takes a stream of commands: start image, load one palette word, or one
// tile data byte. Each byte is buffered in a 32-entry tile RAM. The 32nd byte
// of a tile starts a burst of 64 pixel transactions in raster order, one per
// cycle when the output is not stalled. The first pixel reaches the output
// register through the sequencer start, tile RAM read and palette read
// stages, and input stays stalled until the pipeline has drained. Palette
// entries never written read as color zero; index zero is always transparent.
// tiles_wide and tiles_high are clamped to 512 and should only be written
// while the block is idle.
module packed_tile_palette_decoder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ptpd_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ptpd_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ptpd_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ptpd_pkg::CMD_W-1:0]           cmd,
	input  logic [ptpd_pkg::PAL_ADDR_W-1:0]      palette_index,
	input  logic [ptpd_pkg::PAL_WORD_W-1:0]      palette_word,
	input  logic [ptpd_pkg::BYTE_W-1:0]          tile_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ptpd_pkg::COORD_W-1:0]         pixel_x,
	output logic [ptpd_pkg::COORD_W-1:0]         pixel_y,
	output logic [ptpd_pkg::COLOR_W-1:0]         red,
	output logic [ptpd_pkg::COLOR_W-1:0]         green,
	output logic [ptpd_pkg::COLOR_W-1:0]         blue,
	output logic                                 transparent,
	output logic                                 last
);

	localparam logic [ptpd_pkg::TILE_ADDR_W-1:0] LAST_BYTE = '1;

	logic [ptpd_pkg::CFG_W-1:0]       tiles_wide;
	logic [ptpd_pkg::CFG_W-1:0]       tiles_high;
	logic [ptpd_pkg::CFG_W-1:0]       wide;
	logic [ptpd_pkg::CFG_W-1:0]       high;
	ptpd_pkg::ptpd_start_t            start;
	ptpd_pkg::ptpd_status_t           status;
	logic                             accept;
	logic                             skip;
	logic                             pal_we;
	logic [ptpd_pkg::PAL_ENTRY_W-1:0] pal_wdata;
	logic                             tile_we;
	logic                             tile_re;
	logic [ptpd_pkg::TILE_ADDR_W-1:0] tile_raddr;
	logic [ptpd_pkg::BYTE_W-1:0]      tile_rdata;
	logic                             pal_re;
	logic [ptpd_pkg::PAL_ADDR_W-1:0]  pal_raddr;
	logic [ptpd_pkg::PAL_ENTRY_W-1:0] pal_rdata;
	logic [ptpd_pkg::TILE_ADDR_W-1:0] pos_q;
	logic [ptpd_pkg::SIDE_W-1:0]      col_q;
	logic [ptpd_pkg::SIDE_W-1:0]      row_q;
	logic                             done_q;
	logic [ptpd_pkg::SIDE_W-1:0]      col_next;
	logic [ptpd_pkg::SIDE_W-1:0]      row_next;

	ptpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tiles_wide(tiles_wide),
		.tiles_high(tiles_high)
	);

	// Input decode. The tile buffer and palette are never written while the
	// pixel pipeline reads them, since input stalls until it drains.
	assign in_stall  = status.busy;
	assign accept    = in_valid && !in_stall;
	assign wide      = ptpd_pkg::clamp_side(tiles_wide);
	assign high      = ptpd_pkg::clamp_side(tiles_high);
	assign skip      = done_q || (wide == '0) || (high == '0) || ({1'b0, row_q} >= high);
	assign pal_we    = accept && (cmd == ptpd_pkg::CMD_PALETTE);
	assign pal_wdata = {palette_word[11:9], palette_word[7:5], palette_word[3:1]};
	assign tile_we   = accept && (cmd == ptpd_pkg::CMD_TILE) && !skip;
	assign col_next  = col_q + 1'b1;
	assign row_next  = row_q + 1'b1;

	assign start.go     = tile_we && (pos_q == LAST_BYTE);
	assign start.base_x = col_q;
	assign start.base_y = row_q;

	ptpd_ram #(
		.WIDTH(ptpd_pkg::BYTE_W),
		.DEPTH(ptpd_pkg::TILE_BYTES)
	) u_tile_buf (
		.clk  (clk),
		.we   (tile_we),
		.waddr(pos_q),
		.wdata(tile_byte),
		.re   (tile_re),
		.raddr(tile_raddr),
		.rdata(tile_rdata)
	);

	ptpd_palette u_palette (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (pal_we),
		.waddr (palette_index),
		.wdata (pal_wdata),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	ptpd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.status     (status),
		.tile_re    (tile_re),
		.tile_raddr (tile_raddr),
		.tile_rdata (tile_rdata),
		.pal_re     (pal_re),
		.pal_raddr  (pal_raddr),
		.pal_rdata  (pal_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.transparent(transparent),
		.last       (last)
	);

	// Tile position state: byte count, tile column and row, image end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (cmd == ptpd_pkg::CMD_START) begin
				pos_q  <= '0;
				col_q  <= '0;
				row_q  <= '0;
				done_q <= 1'b0;
			end else if (cmd == ptpd_pkg::CMD_TILE) begin
				if (skip) begin
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == LAST_BYTE) begin
						if ((col_next == '0) || ({1'b0, col_next} >= wide)) begin
							col_q <= '0;
							row_q <= row_next;
							if ((row_next == '0) || ({1'b0, row_next} >= high)) begin
								done_q <= 1'b1;
							end
						end else begin
							col_q <= col_next;
						end
					end
				end
			end
		end
	end

	// A tile burst starts only with an idle pixel pipeline.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start.go |-> !status.busy)
		else $error("tile burst started while the pixel pipeline was busy");

	// The palette never changes under an active burst.
	a_pal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pal_we |-> !status.busy)
		else $error("palette written during a pixel burst");

	// Within a tile, the column inside the tile steps by one each transaction.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
		(!out_valid || (pixel_x[2:0] == 3'($past(pixel_x[2:0]) + 3'd1))))
		else $error("pixel column within tile did not advance by one");

endmodule
